// ----- rtl/cpt_pkg.sv -----
`default_nettype none

package cpt_pkg;

    // Table geometry.
    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    // Field widths of the input and result beats.
    localparam int MODE_W   = 2;
    localparam int KEY_W    = 32;
    localparam int TS_W     = 32;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 6;
    localparam int CALLS_W  = 32;
    localparam int DEPTH_W  = 16;
    localparam int COST_W   = 32;
    localparam int SUM_W    = 48;

    // Event kinds.
    localparam logic [MODE_W-1:0] MODE_CALL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RET  = 2'd1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NEW      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOENTRY  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OTHER    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DISABLED = 3'd5;

    // Configuration register indexes.
    localparam logic REG_ENABLE = 1'b0;

    // One stored profile entry, kept in the entry RAM.
    typedef struct packed {
        logic [SUM_W-1:0]   sum;
        logic [COST_W-1:0]  max;
        logic [TS_W-1:0]    start;
        logic [DEPTH_W-1:0] depth;
        logic [CALLS_W-1:0] calls;
    } t_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic look;
        logic commit;
    } t_cmd;

    // One result beat.
    typedef struct packed {
        logic [SUM_W-1:0]    cost_sum;
        logic [COST_W-1:0]   cost_peak;
        logic [COST_W-1:0]   cost_last;
        logic [DEPTH_W-1:0]  depth;
        logic [CALLS_W-1:0]  calls_seen;
        logic [SLOT_W-1:0]   entry_index;
        logic [STATUS_W-1:0] status;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/cpt_ram.sv -----
`default_nettype none

module cpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Single write port, single registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/cpt_ctrl.sv -----
`default_nettype none

module cpt_ctrl
    import cpt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_s_valid,
    input  wire logic i_m_ready,
    output logic      o_s_ready,
    output logic      o_m_valid,
    output t_cmd      o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_MOD  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       can_commit;
    logic       accept;

    // The result register is free when empty or being drained this cycle.
    assign can_commit = !r_out_valid || i_m_ready;
    assign o_s_ready  = (r_state == S_IDLE) || ((r_state == S_MOD) && can_commit);
    assign accept     = i_s_valid && o_s_ready;

    assign o_cmd.load   = accept;
    assign o_cmd.look   = (r_state == S_LOOK);
    assign o_cmd.commit = (r_state == S_MOD) && can_commit;
    assign o_m_valid    = r_out_valid;

    // Sequencer: accept, look up, then read-modify-write and hand over.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_state = S_MOD;
            end
            S_MOD: begin
                if (can_commit) begin
                    n_state = accept ? S_LOOK : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Result beat valid flag.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_m_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/cpt_dp.sv -----
`default_nettype none

module cpt_dp
    import cpt_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    input  wire logic              i_enable,
    input  wire logic [MODE_W-1:0] i_mode,
    input  wire logic [KEY_W-1:0]  i_key,
    input  wire logic [TS_W-1:0]   i_ts,
    output t_result                o_result
);

    // Latched event.
    logic [MODE_W-1:0] r_mode;
    logic [KEY_W-1:0]  r_key;
    logic [TS_W-1:0]   r_ts;

    // Key store, valid bits and fill count.
    logic [KEY_W-1:0]   r_keys [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    logic [CNT_W-1:0]   r_used;

    // Lookup results.
    logic               r_hit;
    logic               r_full;
    logic [IDX_W-1:0]   r_slot;
    logic [ENTRIES-1:0] hit_vec;
    logic [IDX_W-1:0]   hit_idx;
    logic               hit_any;

    // Update stage.
    t_entry               rd_entry;
    t_entry               cur;
    t_entry               nxt;
    logic [STATUS_W-1:0]  status;
    logic                 show;
    logic                 wr;
    logic                 alloc;
    logic [COST_W-1:0]    dt;
    logic [COST_W-1:0]    last;
    logic [SUM_W:0]       sum_ext;
    t_result              res;
    t_result              r_result;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_key  <= i_key;
            r_ts   <= i_ts;
        end
    end

    // Parallel key compare; keys are unique, so the match vector is one-hot
    // or empty and the slot number is an OR of the matching indexes.
    always_comb begin
        hit_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            hit_vec[i] = r_valid[i] && (r_keys[i] == r_key);
            if (hit_vec[i]) begin
                hit_idx = hit_idx | IDX_W'(i);
            end
        end
        hit_any = |hit_vec;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.look) begin
            r_hit  <= hit_any;
            r_full <= (r_used == CNT_W'(ENTRIES));
            r_slot <= hit_any ? hit_idx : r_used[IDX_W-1:0];
        end
    end

    cpt_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit && wr),
        .i_waddr (r_slot),
        .i_wdata (nxt),
        .i_re    (i_cmd.look),
        .i_raddr (hit_idx),
        .o_rdata (rd_entry)
    );

    // A freshly allocated entry starts cleared.
    assign cur     = r_hit ? rd_entry : '0;
    assign dt      = r_ts - cur.start;
    assign sum_ext = {1'b0, cur.sum} + {{(SUM_W + 1 - COST_W){1'b0}}, dt};

    // Event decode and entry update.
    always_comb begin
        status = ST_OTHER;
        show   = 1'b0;
        wr     = 1'b0;
        alloc  = 1'b0;
        last   = '0;
        nxt    = cur;
        if (!i_enable) begin
            status = ST_DISABLED;
        end else begin
            unique case (r_mode)
                MODE_CALL: begin
                    if (!r_hit && r_full) begin
                        status = ST_FULL;
                    end else begin
                        status = r_hit ? ST_UPDATED : ST_NEW;
                        alloc  = !r_hit;
                        wr     = 1'b1;
                        show   = 1'b1;
                        if (cur.depth == '0) begin
                            nxt.start = r_ts;
                        end
                        if (cur.depth != '1) begin
                            nxt.depth = cur.depth + 1'b1;
                        end
                        if (cur.calls != '1) begin
                            nxt.calls = cur.calls + 1'b1;
                        end
                    end
                end
                MODE_RET: begin
                    if (!r_hit) begin
                        status = ST_NOENTRY;
                    end else if (cur.depth == '0) begin
                        status = ST_NOENTRY;
                        show   = 1'b1;
                    end else begin
                        status    = ST_UPDATED;
                        show      = 1'b1;
                        wr        = 1'b1;
                        nxt.depth = cur.depth - 1'b1;
                        // Outermost call closes: fold its duration in.
                        if (cur.depth == DEPTH_W'(1)) begin
                            last = dt;
                            if (dt > cur.max) begin
                                nxt.max = dt;
                            end
                            nxt.sum = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
                        end
                    end
                end
                default: begin
                    status = ST_OTHER;
                end
            endcase
        end
    end

    // Result fields other than the status are zero unless an entry is reported.
    always_comb begin
        res             = '0;
        res.status      = status;
        if (show) begin
            res.entry_index = SLOT_W'(r_slot);
            res.calls_seen  = nxt.calls;
            res.depth       = nxt.depth;
            res.cost_last   = last;
            res.cost_peak   = nxt.max;
            res.cost_sum    = nxt.sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_result <= res;
        end
    end

    // Key store is written on allocation only.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (i_cmd.commit && alloc && (r_slot == IDX_W'(i))) begin
                r_keys[i] <= r_key;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_used  <= '0;
        end else if (i_cmd.commit && alloc) begin
            r_valid[r_slot] <= 1'b1;
            r_used          <= r_used + 1'b1;
        end
    end

    assign o_result = r_result;

endmodule

`default_nettype wire

// ----- rtl/call_profile_table.sv -----
// An accepted beat is latched, then looked up, then committed by the
// read-modify-write of the entry RAM into the result register, which stalls
// while the result register is full; a new beat is taken in the update cycle.
// Reset is synchronous and active low: it clears the entry valid bits, the
// fill count, the enable register and the handshake state; the entry RAM
// needs no clearing pass, so the block takes beats right after reset.
`default_nettype none

module call_profile_table
    import cpt_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // Input stream.
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata: mode[1:0], function_key[33:2], timestamp[65:34], zero fill.
    input  wire logic [71:0]  s_axis_tdata,
    // Result stream.
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // tdata: status[2:0], entry_index[8:3], calls_seen[40:9], depth[56:41],
    // cost_last[88:57], cost_peak[120:89], cost_sum[168:121], zero fill.
    output logic [175:0]      m_axis_tdata,
    // Configuration port.
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cmd    cmd;
    t_result result;
    logic    r_enable;

    // Configuration register; the register index is the word address.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_ENABLE)) begin
            r_enable <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == REG_ENABLE) ? {31'd0, r_enable} : 32'd0;

    cpt_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .o_cmd     (cmd)
    );

    cpt_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_enable (r_enable),
        .i_mode   (s_axis_tdata[1:0]),
        .i_key    (s_axis_tdata[33:2]),
        .i_ts     (s_axis_tdata[65:34]),
        .o_result (result)
    );

    // Result beat packing, status in the lowest bits.
    assign m_axis_tdata = {7'd0, result};

endmodule

`default_nettype wire
